// File: design/assert_macros.svh
// Assertion macros used by the top RTL file of the hit counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: design/hftc_pkg.sv
// Package of the hashed first-touch hit counter: sizes, constants, types.
`default_nettype none

package hftc_pkg;

  // Table geometry
  localparam int unsigned SLOTS = 4096;
  localparam int unsigned IDX_W = $clog2(SLOTS);

  // Field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned ORDER_W = 13;
  localparam int unsigned HITS_W  = 32;

  // Hash constants
  localparam logic [31:0] HASH_MUL_ADDR = 32'd2654435761;
  localparam logic [31:0] HASH_MUL_BASE = 32'd40503;
  localparam int unsigned HASH_SHIFT    = 11;
  localparam int unsigned HASH_W        = 32 - HASH_SHIFT;

  // Slot reduction: restoring compare/subtract, one step per cycle
  localparam bit          SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam int unsigned MOD_STEPS  = HASH_W - IDX_W + 1;
  localparam logic [HASH_W-1:0] MOD_LAST = HASH_W'(SLOTS);
  localparam logic [HASH_W-1:0] MOD_INIT = MOD_LAST << (MOD_STEPS - 1);

  // Saturation limits
  localparam logic [ORDER_W-1:0] ORDER_MAX = '1;
  localparam logic [HITS_W-1:0]  HITS_MAX  = '1;

  // Request codes
  localparam logic OP_ENTER = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One table slot as stored in memory
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  base;
    logic [ORDER_W-1:0] order;
    logic [HITS_W-1:0]  hits;
  } slot_t;

  // Hash unit handshake
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] entry_addr;
    logic [ADDR_W-1:0] module_base;
  } hash_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] idx;
  } hash_rsp_t;

  // Main sequencer
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE
  } ctrl_state_e;

  // Hash sequencer
  typedef enum logic [2:0] {
    H_IDLE,
    H_MUL_A,
    H_MUL_B,
    H_SUM,
    H_MOD,
    H_DONE
  } hash_state_e;

endpackage

`default_nettype wire

// File: design/hftc_if.sv
// Request and response channel interfaces of the hit counter.
`default_nettype none

interface hftc_req_if;
  import hftc_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] entry_addr;
  logic [ADDR_W-1:0] module_base;

  modport source (output valid, op, entry_addr, module_base, input ready);
  modport sink   (input valid, op, entry_addr, module_base, output ready);
endinterface

interface hftc_rsp_if;
  import hftc_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [ORDER_W-1:0] first_order;
  logic [HITS_W-1:0]  hit_total;
  logic               table_full;

  modport source (output valid, found, first_order, hit_total, table_full, input ready);
  modport sink   (input valid, found, first_order, hit_total, table_full, output ready);
endinterface

`default_nettype wire

// File: design/hashed_first_touch_hit_counter_top.sv
// Hashed first-touch hit counter: open-addressed table with linear probing.
//
// Channels: req_i (sink) carries op, entry_addr and module_base; rsp_o
// (source) returns found, first_order, hit_total and table_full, exactly one
// response per request, in request order. A transaction completes on a
// rising edge with valid and ready high.
// Sequence: the hash unit runs two multiplies through one shared multiplier,
// a sum and a done state, plus a compare/subtract reduction when SLOTS is
// not a power of two. Each probe is then a registered read of the slot
// memory: a request that hits its home slot needs one read after the hash,
// and each extra probe adds one more read. One request is in flight at a
// time: a new request is taken only once the last one has resolved its
// probes, paced by the hash sequencer and the single read port.
// Reset: the table is swept clear, one slot per cycle, with req_i.ready
// low, then requests are taken.
// Stall: a response waits in the output register while rsp_o.ready is low;
// the next request is accepted and hashed, but it does not finish or write
// the table until the pending response is taken.
`default_nettype none
`include "assert_macros.svh"

module hashed_first_touch_hit_counter_top (
  input wire logic clk_i,
  input wire logic rst_ni,
  hftc_req_if.sink   req_i,
  hftc_rsp_if.source rsp_o
);
  import hftc_pkg::*;

  ctrl_state_e        state_q, state_d;
  logic               op_q;
  logic [ADDR_W-1:0]  key_addr_q, key_base_q;
  logic [IDX_W-1:0]   idx_q, idx_d, idx_next;
  logic [IDX_W-1:0]   probe_q, probe_d;
  logic [IDX_W-1:0]   clr_q;
  logic [ORDER_W-1:0] dist_q, dist_new;

  logic               out_valid_q;
  logic               found_q, full_q;
  logic [ORDER_W-1:0] order_q;
  logic [HITS_W-1:0]  hits_q;

  logic               res_found, res_full;
  logic [ORDER_W-1:0] res_order;
  logic [HITS_W-1:0]  res_hits;

  hash_req_t hash_req;
  hash_rsp_t hash_rsp;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  slot_t            ram_wdata, ram_rdata;

  logic key_zero, slot_empty, slot_match, last_probe;
  logic resolve, out_free, fire, do_insert;

  // Hash unit
  hftc_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hash_req),
    .rsp_o  (hash_rsp)
  );

  // Slot memory
  hftc_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Probe decode
  always_comb begin
    key_zero   = (key_addr_q == '0);
    slot_empty = (ram_rdata.addr == '0);
    slot_match = !slot_empty && (ram_rdata.addr == key_addr_q) &&
                 (ram_rdata.base == key_base_q);
    last_probe = (probe_q == IDX_W'(SLOTS - 1));
    resolve    = key_zero || slot_empty || slot_match || last_probe;
    out_free   = !out_valid_q || rsp_o.ready;
    fire       = (state_q == ST_PROBE) && resolve && out_free;
    do_insert  = !key_zero && slot_empty && (op_q == OP_ENTER);
    idx_next   = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
    dist_new   = (dist_q != ORDER_MAX) ? dist_q + 1'b1 : dist_q;
  end

  // Response of the current probe
  always_comb begin
    res_found = 1'b0;
    res_full  = 1'b0;
    res_order = '0;
    res_hits  = '0;
    if (key_zero) begin
      res_found = 1'b0;
    end else if (slot_match) begin
      res_found = 1'b1;
      res_order = ram_rdata.order;
      res_hits  = ram_rdata.hits;
      if (op_q == OP_ENTER && ram_rdata.hits != HITS_MAX) res_hits = ram_rdata.hits + 1'b1;
    end else if (slot_empty) begin
      if (op_q == OP_ENTER) begin
        res_order = dist_new;
        res_hits  = HITS_W'(1);
      end
    end else begin
      res_full = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == IDX_W'(SLOTS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (req_i.valid) state_d = ST_HASH;
      ST_HASH:  if (hash_rsp.done) state_d = ST_PROBE;
      ST_PROBE: if (fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: request ready, hash start, memory ports, probe index
  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    hash_req.start       = (state_q == ST_IDLE) && req_i.valid;
    hash_req.entry_addr  = req_i.entry_addr;
    hash_req.module_base = req_i.module_base;

    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    idx_d     = idx_q;
    probe_d   = probe_q;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      ST_HASH: begin
        if (hash_rsp.done) begin
          ram_re    = 1'b1;
          ram_raddr = hash_rsp.idx;
          idx_d     = hash_rsp.idx;
          probe_d   = '0;
        end
      end
      ST_PROBE: begin
        if (!resolve) begin
          // Occupied by another key: step to the next slot
          ram_re    = 1'b1;
          ram_raddr = idx_next;
          idx_d     = idx_next;
          probe_d   = probe_q + 1'b1;
        end else if (fire && !key_zero && (op_q == OP_ENTER) &&
                     (slot_match || slot_empty)) begin
          ram_we    = 1'b1;
          ram_wdata = slot_match ?
                      {ram_rdata.addr, ram_rdata.base, ram_rdata.order, res_hits} :
                      {key_addr_q, key_base_q, dist_new, HITS_W'(1)};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      dist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (fire && do_insert) dist_q <= dist_new;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, probe position and response payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req_i.valid) begin
      op_q       <= req_i.op;
      key_addr_q <= req_i.entry_addr;
      key_base_q <= req_i.module_base;
    end
    idx_q   <= idx_d;
    probe_q <= probe_d;
    if (fire) begin
      found_q <= res_found;
      order_q <= res_order;
      hits_q  <= res_hits;
      full_q  <= res_full;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.first_order = order_q;
  assign rsp_o.hit_total   = hits_q;
  assign rsp_o.table_full  = full_q;

  // Checks
  `ASSERT_SAME(a_hash_done_when_waiting, hash_rsp.done, state_q == ST_HASH)
  `ASSERT_NEXT(a_dist_monotonic, 1'b1, dist_q >= $past(dist_q))
  `ASSERT_SAME(a_rsp_from_probe, $rose(out_valid_q), $past(state_q) == ST_PROBE)
  `ASSERT_SAME(a_probe_write_keyed, ram_we && state_q == ST_PROBE, ram_wdata.addr != '0)

endmodule

`default_nettype wire

// File: design/hftc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hftc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/hftc_hash.sv
// Iterative hash unit: one shared multiplier, then a compare/subtract reduction when SLOTS is not a power of two.
`default_nettype none

module hftc_hash (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire hftc_pkg::hash_req_t req_i,
  output hftc_pkg::hash_rsp_t      rsp_o
);
  import hftc_pkg::*;

  hash_state_e       state_q, state_d;
  logic [ADDR_W-1:0] key_a_q, key_b_q;
  logic [31:0]       prod_q, acc_q;
  logic [HASH_W-1:0] rem_q, rem_d;
  logic [HASH_W-1:0] cand_q, cand_d;
  logic [31:0]       mul_a, mul_b;
  logic [31:0]       prod_lo;
  logic [31:0]       sum;

  // Shared multiplier, operands picked by the sequencer; only the low word is kept
  always_comb begin
    mul_a   = (state_q == H_MUL_A) ? key_a_q : key_b_q;
    mul_b   = (state_q == H_MUL_A) ? HASH_MUL_ADDR : HASH_MUL_BASE;
    prod_lo = mul_a * mul_b;
    sum     = acc_q + prod_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      H_IDLE:  if (req_i.start) state_d = H_MUL_A;
      H_MUL_A: state_d = H_MUL_B;
      H_MUL_B: state_d = H_SUM;
      H_SUM:   state_d = SLOTS_POW2 ? H_DONE : H_MOD;
      H_MOD:   if (cand_q == MOD_LAST) state_d = H_DONE;
      H_DONE:  state_d = H_IDLE;
      default: state_d = H_IDLE;
    endcase
  end

  // Reduction datapath
  always_comb begin
    rem_d  = rem_q;
    cand_d = cand_q;
    case (state_q)
      H_SUM: begin
        rem_d  = sum[31:HASH_SHIFT];
        cand_d = MOD_INIT;
      end
      H_MOD: begin
        if (rem_q >= cand_q) rem_d = rem_q - cand_q;
        cand_d = cand_q >> 1;
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    rsp_o.done = (state_q == H_DONE);
    rsp_o.idx  = rem_q[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == H_IDLE && req_i.start) begin
      key_a_q <= req_i.entry_addr;
      key_b_q <= req_i.module_base;
    end
    prod_q <= prod_lo;
    if (state_q == H_MUL_B) acc_q <= prod_q;
    rem_q  <= rem_d;
    cand_q <= cand_d;
  end

endmodule

`default_nettype wire
